// File: rtl/phaser_pkg.sv
// Phaser package: fixed-point constants, register indexes, sequencer states
// and the request struct for the shared multiply unit. No dependencies.
package phaser_pkg;

	localparam int unsigned PROD_W    = 50;	// 32 x 18 signed product
	localparam int unsigned SUM_W     = 51;	// two products summed
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WET_MIX    = 3'd3;

	localparam logic [16:0]        Q15_ONE   = 17'd32768;
	localparam logic [14:0]        FB_MAX    = 15'd31130;
	localparam logic signed [31:0] G_BASE    = 32'sd3277;
	localparam logic signed [17:0] G_SPAN    = 18'sd27853;
	localparam logic signed [31:0] Q28_ONE   = 32'sd268435456;
	localparam logic signed [17:0] OUT_SCALE = 18'sd32767;

	// registers already capped to their legal ranges
	typedef struct packed {
		logic [30:0] step;
		logic [15:0] depth;
		logic [14:0] fbg;
		logic [15:0] mix;
	} cfg_t;

	// one request to the shared multiply/round/saturate unit
	typedef struct packed {
		logic               issue;
		logic               acc;	// add the previous sum before rounding
		logic               neg;	// base minus rounded product
		logic               scale;	// output scaling: truncate toward zero by 2^28
		logic signed [31:0] a;
		logic signed [17:0] b;
		logic signed [31:0] base;
	} mac_op_t;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_SWEEP = 10'b0000000010,
		ST_GAIN  = 10'b0000000100,
		ST_FEED  = 10'b0000001000,
		ST_YSTG  = 10'b0000010000,
		ST_MSTG  = 10'b0000100000,
		ST_MIXA  = 10'b0001000000,
		ST_MIXB  = 10'b0010000000,
		ST_SCALE = 10'b0100000000,
		ST_OUTW  = 10'b1000000000
	} state_t;

endpackage

// File: rtl/phaser_mac.sv
// Shared arithmetic unit: registered 32x18 multiply, then accumulate,
// Q1.15 round and saturating add (or output scaling). Uses phaser_pkg.
module phaser_mac (
	input  logic                clk,
	input  phaser_pkg::mac_op_t op,
	output logic signed [31:0]  res
);
	import phaser_pkg::*;

	localparam int unsigned R_W = SUM_W - 15;
	localparam int unsigned V_W = R_W + 2;
	localparam int unsigned S_W = SUM_W - 28;

	logic signed [PROD_W-1:0] prod_s1;
	logic                     acc_s1;
	logic                     neg_s1;
	logic                     scale_s1;
	logic signed [31:0]       base_s1;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  t_rnd;
	logic signed [SUM_W-1:0]  t_scl;
	logic signed [R_W-1:0]    rnd;
	logic signed [V_W-1:0]    v;
	logic signed [S_W-1:0]    scl;

	always_ff @(posedge clk) begin
		if (op.issue) begin
			prod_s1  <= $signed(op.a) * $signed(op.b);
			acc_s1   <= op.acc;
			neg_s1   <= op.neg;
			scale_s1 <= op.scale;
			base_s1  <= op.base;
		end
		acc_q <= sum;
	end

	always_comb begin
		sum   = SUM_W'(prod_s1) + (acc_s1 ? acc_q : '0);
		// round to nearest, ties up: floor((p + 2^14) / 2^15)
		t_rnd = sum + SUM_W'(16384);
		rnd   = t_rnd[SUM_W-1:15];
		v     = neg_s1 ? (V_W'(base_s1) - V_W'(rnd)) : (V_W'(base_s1) + V_W'(rnd));
		// truncation toward zero for the final scaling
		t_scl = sum + (sum[SUM_W-1] ? SUM_W'(268435455) : '0);
		scl   = t_scl[SUM_W-1:28];
		if (scale_s1) begin
			res = 32'(scl);
		end else if (v[V_W-1] && !(&v[V_W-1:31])) begin
			res = 32'sh8000_0000;
		end else if (!v[V_W-1] && (|v[V_W-1:31])) begin
			res = 32'sh7fff_ffff;
		end else begin
			res = v[31:0];
		end
	end

endmodule

// File: rtl/phaser_ctrl.sv
// Sequencer for the phaser: LFO, feedback, allpass chain state and mix,
// all driven through the shared multiply unit. Uses phaser_pkg.
module phaser_ctrl #(
	parameter int STAGES = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  phaser_pkg::cfg_t    cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  sample_in,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  sample_out,
	output phaser_pkg::mac_op_t op,
	input  logic signed [31:0]  res
);
	import phaser_pkg::*;

	localparam int IW = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam logic [IW-1:0] LAST = IW'(STAGES - 1);

	state_t             state_q;
	logic               phase_q;	// 0: issue, 1: result ready
	logic [IW-1:0]      idx_q;
	logic [31:0]        lfo_q;
	logic signed [31:0] fb_q;
	logic signed [31:0] mem_q [STAGES];
	logic               out_valid_q;

	logic signed [15:0] smp_q;
	logic [16:0]        coef_q;	// sweep, then allpass coefficient
	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic signed [31:0] si_q;
	logic signed [31:0] m_q;
	logic signed [15:0] out_q;

	logic [32:0] ph_neg;
	logic [16:0] tri_val;
	logic        out_free;
	logic        out_set;
	logic        last_stage;

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign sample_out = out_q;
	assign out_free   = !out_valid_q || !out_stall;
	// a new result goes out of the scaling step or the output wait
	assign out_set    = out_free && ((state_q == ST_OUTW) || (state_q == ST_SCALE && phase_q));
	assign last_stage = (idx_q == LAST);

	always_comb begin
		ph_neg  = 33'h1_0000_0000 - {1'b0, lfo_q};
		tri_val = lfo_q[31] ? ph_neg[32:16] : {1'b0, lfo_q[31:16]};
	end

	always_comb begin
		op       = '0;
		op.issue = !phase_q;
		unique case (state_q)
			ST_SWEEP: begin
				op.a = {15'b0, tri_val};
				op.b = {2'b0, cfg.depth};
			end
			ST_GAIN: begin
				op.a    = {15'b0, coef_q};
				op.b    = G_SPAN;
				op.base = G_BASE;
			end
			ST_FEED: begin
				op.a    = fb_q;
				op.b    = {3'b0, cfg.fbg};
				op.base = {{3{smp_q[15]}}, smp_q, 13'b0};
			end
			ST_YSTG: begin
				op.a    = y_q;
				op.b    = {1'b0, coef_q};
				op.base = mem_q[idx_q];
				op.neg  = 1'b1;
			end
			ST_MSTG: begin
				op.a    = y_q;
				op.b    = {1'b0, coef_q};
				op.base = si_q;
			end
			ST_MIXA: begin
				op.a = x_q;
				op.b = {1'b0, Q15_ONE - {1'b0, cfg.mix}};
			end
			ST_MIXB: begin
				op.a   = y_q;
				op.b   = {2'b0, cfg.mix};
				op.acc = 1'b1;
			end
			ST_SCALE: begin
				op.a     = m_q;
				op.b     = OUT_SCALE;
				op.scale = 1'b1;
			end
			ST_IDLE, ST_OUTW: begin
				op.issue = 1'b0;
			end
			default: begin
				op.issue = 1'b0;
			end
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= 1'b0;
			idx_q       <= '0;
			lfo_q       <= '0;
			fb_q        <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < STAGES; i++) begin
				mem_q[i] <= '0;
			end
		end else begin
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					phase_q <= 1'b0;
					if (in_valid) begin
						lfo_q   <= lfo_q + {1'b0, cfg.step};
						state_q <= ST_SWEEP;
					end
				end
				ST_OUTW: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						unique case (state_q)
							ST_SWEEP: state_q <= ST_GAIN;
							ST_GAIN:  state_q <= ST_FEED;
							ST_FEED: begin
								idx_q   <= '0;
								state_q <= ST_YSTG;
							end
							ST_YSTG:  state_q <= ST_MSTG;
							ST_MSTG: begin
								mem_q[idx_q] <= res;
								if (last_stage) begin
									fb_q    <= y_q;
									state_q <= ST_MIXA;
								end else begin
									idx_q   <= idx_q + 1'b1;
									state_q <= ST_YSTG;
								end
							end
							ST_MIXA:  state_q <= ST_MIXB;
							ST_MIXB:  state_q <= ST_SCALE;
							ST_SCALE: begin
								if (out_free) begin
									state_q <= ST_IDLE;
								end else begin
									state_q <= ST_OUTW;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			smp_q <= sample_in;
		end
		if (phase_q) begin
			unique case (state_q)
				ST_SWEEP, ST_GAIN: coef_q <= res[16:0];
				ST_FEED: begin
					x_q <= res;
					y_q <= res;
				end
				ST_YSTG: begin
					si_q <= y_q;
					y_q  <= res;
				end
				ST_MIXB: begin
					if (res > Q28_ONE) begin
						m_q <= Q28_ONE;
					end else if (res < -Q28_ONE) begin
						m_q <= -Q28_ONE;
					end else begin
						m_q <= res;
					end
				end
				ST_SCALE: begin
					m_q <= res;
					// a stalled result keeps its payload
					if (out_free) begin
						out_q <= res[15:0];
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == ST_OUTW && out_free) begin
			out_q <= m_q[15:0];
		end
	end

endmodule

// File: rtl/phaser_allpass_audio_effect_top.sv
// Phaser top level: configuration registers with range capping, the
// sequencer and the shared multiply unit. Uses phaser_pkg, phaser_ctrl, phaser_mac.
// Samples are taken one at a time: the input stalls until the sequencer is back
// in idle; every product goes through the single multiply unit in turn, two per
// allpass stage.
// Reset (arst_n low) clears LFO phase, allpass memories and feedback, and loads
// the register defaults; no clearing pass is needed.
module phaser_allpass_audio_effect_top #(
	parameter int STAGES = 6
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input sample channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [15:0]                 sample_in,
	// output sample channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [15:0]                 sample_out,
	// register write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [phaser_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                        cfg_data
);
	import phaser_pkg::*;

	logic [30:0] step_q;
	logic [15:0] depth_q;
	logic [14:0] fbg_q;
	logic [15:0] mix_q;

	cfg_t    cfg;
	mac_op_t op;
	logic signed [31:0] res;

	// writes are always taken; they must arrive only while the block is idle, which the block does not enforce
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= 31'd48696;
			depth_q <= 16'd22938;
			fbg_q   <= 15'd9830;
			mix_q   <= 16'd16384;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PHASE_STEP: step_q  <= cfg_data[30:0];
				REG_DEPTH:      depth_q <= cfg_data[15:0];
				REG_FEEDBACK:   fbg_q   <= cfg_data[14:0];
				REG_WET_MIX:    mix_q   <= cfg_data[15:0];
				default: begin
					// unknown index: transfer is dropped
				end
			endcase
		end
	end

	// out-of-range settings saturate: depth and mix at 1.0, feedback at 0.95
	always_comb begin
		cfg.step  = step_q;
		cfg.depth = ({1'b0, depth_q} > Q15_ONE) ? Q15_ONE[15:0] : depth_q;
		cfg.fbg   = (fbg_q > FB_MAX) ? FB_MAX : fbg_q;
		cfg.mix   = ({1'b0, mix_q} > Q15_ONE) ? Q15_ONE[15:0] : mix_q;
	end

	phaser_ctrl #(
		.STAGES(STAGES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample_out(sample_out),
		.op        (op),
		.res       (res)
	);

	phaser_mac u_mac (
		.clk(clk),
		.op (op),
		.res(res)
	);

endmodule
